### rtl/core/mdh_pkg.sv
`default_nettype none

package mdh_pkg;

   localparam int MAX_DIMS     = 4;
   localparam int BIN_BITS     = 4;
   localparam int BINS_BITS    = BIN_BITS + 1;
   localparam int DIM_BITS     = $clog2(MAX_DIMS);
   localparam int DIM_CNT_BITS = $clog2(MAX_DIMS + 1);
   localparam int ADDR_BITS    = BIN_BITS * MAX_DIMS;
   localparam int STORE_DEPTH  = 1 << ADDR_BITS;
   localparam int LEN_BITS     = ADDR_BITS + 1;
   localparam int RESULT_BITS  = 48;
   localparam int OPND_BITS    = 32;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 5;
   localparam int ACT_BITS     = 3;
   localparam int DIMS_BITS    = 3;

   localparam logic [ACT_BITS-1:0] ACT_READ  = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_WRITE = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_ADD   = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_SUB   = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_FILL  = 3'd4;
   localparam logic [ACT_BITS-1:0] ACT_SUM   = 3'd5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMS  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BINS0 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BINS1 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BINS2 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BINS3 = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_READ,
      ST_MODIFY,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 step;
      logic [LEN_BITS-1:0]  load_value;
      logic [BINS_BITS-1:0] factor;
      logic [BIN_BITS-1:0]  addend;
   } mac_ctl_type;

   function automatic logic [DIMS_BITS-1:0] eff_dims(input logic [DIMS_BITS-1:0] raw);
      logic [DIMS_BITS-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = DIMS_BITS'(1);
      end else if (raw > DIMS_BITS'(MAX_DIMS)) begin
         res = DIMS_BITS'(MAX_DIMS);
      end
      return res;
   endfunction

   function automatic logic [BINS_BITS-1:0] eff_bins(input logic [CSR_DAT_BITS-1:0] raw);
      logic [BINS_BITS-1:0] res;
      res = BINS_BITS'(raw);
      if (raw == '0) begin
         res = BINS_BITS'(1);
      end else if (raw > CSR_DAT_BITS'(1 << BIN_BITS)) begin
         res = BINS_BITS'(1 << BIN_BITS);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/mdh_ram.sv
`default_nettype none

module mdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

### rtl/core/mdh_mac.sv
`default_nettype none

module mdh_mac (
   input  wire logic                         clock,
   input  wire mdh_pkg::mac_ctl_type         ctl,
   output logic      [mdh_pkg::LEN_BITS-1:0] acc
);
   import mdh_pkg::*;

   logic [LEN_BITS-1:0] acc_ff;
   logic [LEN_BITS-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = ctl.load_value;
      end else if (ctl.step) begin
         acc_in = LEN_BITS'(acc_ff * ctl.factor) + LEN_BITS'(ctl.addend);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### rtl/core/multidim_histogram_store.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  action, coord0..coord3, operand_value
// rsp       out        rsp_valid / rsp_stall  result_value, range_error
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// A single-entry action forms its flat index over the n dimensions in use on the shared
// multiply-add unit, then reads and modifies the entry before the result is transferred.
// Fill and sum first form the used length L there, then sweep one entry per cycle on the
// single memory port; a range error or an unused action goes straight to the result.
// After reset a clearing pass zeroes all 65536 entries, with req_stall high. A result held
// by rsp_stall delays the return to idle.
`default_nettype none

module multidim_histogram_store #(
   parameter int COUNT_BITS = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic        [mdh_pkg::ACT_BITS-1:0]      req_action,
   input  wire logic        [mdh_pkg::BIN_BITS-1:0]      req_coord0,
   input  wire logic        [mdh_pkg::BIN_BITS-1:0]      req_coord1,
   input  wire logic        [mdh_pkg::BIN_BITS-1:0]      req_coord2,
   input  wire logic        [mdh_pkg::BIN_BITS-1:0]      req_coord3,
   input  wire logic signed [mdh_pkg::OPND_BITS-1:0]     req_operand_value,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic signed      [mdh_pkg::RESULT_BITS-1:0]   rsp_result_value,
   output logic                                          rsp_range_error,
   input  wire logic                                     csr_write_enable,
   input  wire logic        [mdh_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic        [mdh_pkg::CSR_DAT_BITS-1:0]  csr_write_data
);
   import mdh_pkg::*;

   state_type state_ff, state_in;

   logic [DIMS_BITS-1:0]    dims_ff;
   logic [CSR_DAT_BITS-1:0] bins_ff [MAX_DIMS];

   logic [ACT_BITS-1:0]         act_ff;
   logic [BIN_BITS-1:0]         coord_ff [MAX_DIMS];
   logic signed [OPND_BITS-1:0] opnd_ff;
   logic                        err_ff;
   logic signed [RESULT_BITS-1:0] res_ff;
   logic [DIM_CNT_BITS-1:0]     dcnt_ff;
   logic [ADDR_BITS-1:0]        addr_ff;
   logic                        pend_ff;

   logic                          rsp_valid_ff;
   logic signed [RESULT_BITS-1:0] rsp_value_ff;
   logic                          rsp_err_ff;

   logic [BIN_BITS-1:0]   req_coord [MAX_DIMS];
   logic [DIMS_BITS-1:0]  n_dims;
   logic                  accept;
   logic                  single_now;
   logic                  single_ff;
   logic                  err_now;
   logic                  out_free;
   logic                  sweep_last;
   logic [DIM_BITS-1:0]   dim_sel;
   logic [LEN_BITS-1:0]   acc;
   mac_ctl_type           mac_ctl;

   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] mem_rdata;
   logic [COUNT_BITS-1:0] opnd_cnt;

   assign req_coord[0] = req_coord0;
   assign req_coord[1] = req_coord1;
   assign req_coord[2] = req_coord2;
   assign req_coord[3] = req_coord3;

   assign n_dims     = eff_dims(dims_ff);
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign single_now = (req_action <= ACT_SUB);
   assign single_ff  = (act_ff <= ACT_SUB);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign dim_sel    = DIM_BITS'(dcnt_ff - 1'b1);
   assign opnd_cnt   = COUNT_BITS'(opnd_ff);
   assign sweep_last = ({1'b0, addr_ff} == (acc - 1'b1));

   always_comb begin
      err_now = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if ((DIMS_BITS'(d) < n_dims) &&
             ({1'b0, req_coord[d]} >= eff_bins(bins_ff[d]))) begin
            err_now = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (single_now) begin
                  state_in = err_now ? ST_DONE : ST_MAC;
               end else if (req_action == ACT_FILL || req_action == ACT_SUM) begin
                  state_in = ST_MAC;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MAC: begin
            if (dcnt_ff == '0) begin
               state_in = single_ff ? ST_READ : ST_SWEEP;
            end
         end
         ST_READ:   state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_DONE;
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = (act_ff == ACT_SUM) ? ST_DRAIN : ST_DONE;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_we             = 1'b0;
      mem_addr           = acc[ADDR_BITS-1:0];
      mem_wdata          = opnd_cnt;
      mac_ctl.load       = 1'b0;
      mac_ctl.step       = 1'b0;
      mac_ctl.load_value = single_now ?
                           LEN_BITS'(req_coord[DIM_BITS'(n_dims - 1'b1)]) :
                           LEN_BITS'(1);
      mac_ctl.factor     = eff_bins(bins_ff[dim_sel]);
      mac_ctl.addend     = single_ff ? coord_ff[dim_sel] : '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = addr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            mac_ctl.load = accept;
         end
         ST_MAC: begin
            mac_ctl.step = (dcnt_ff != '0);
         end
         ST_MODIFY: begin
            mem_we = (act_ff != ACT_READ);
            case (act_ff)
               ACT_WRITE: mem_wdata = opnd_cnt;
               ACT_ADD:   mem_wdata = mem_rdata + opnd_cnt;
               default:   mem_wdata = mem_rdata - opnd_cnt;
            endcase
         end
         ST_SWEEP: begin
            mem_addr = addr_ff;
            mem_we   = (act_ff == ACT_FILL);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_BITS'(1);
         for (int d = 0; d < MAX_DIMS; d++) begin
            bins_ff[d] <= CSR_DAT_BITS'(1);
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIMS:  dims_ff    <= csr_write_data[DIMS_BITS-1:0];
            CSR_BINS0: bins_ff[0] <= csr_write_data;
            CSR_BINS1: bins_ff[1] <= csr_write_data;
            CSR_BINS2: bins_ff[2] <= csr_write_data;
            CSR_BINS3: bins_ff[3] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         dcnt_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == ST_SWEEP) && (act_ff == ACT_SUM);
         if (state_ff == ST_CLEAR || state_ff == ST_SWEEP) begin
            addr_ff <= addr_ff + 1'b1;
         end else if (accept) begin
            addr_ff <= '0;
         end
         if (accept) begin
            dcnt_ff <= single_now ? DIM_CNT_BITS'(n_dims - 1'b1) : DIM_CNT_BITS'(n_dims);
         end else if (state_ff == ST_MAC && dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         for (int d = 0; d < MAX_DIMS; d++) begin
            coord_ff[d] <= req_coord[d];
         end
         opnd_ff <= req_operand_value;
         err_ff  <= single_now && err_now;
         res_ff  <= '0;
      end else if (state_ff == ST_MODIFY && act_ff == ACT_READ) begin
         res_ff <= RESULT_BITS'($signed(mem_rdata));
      end else if (pend_ff) begin
         res_ff <= res_ff + RESULT_BITS'($signed(mem_rdata));
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_value_ff <= res_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   mdh_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   mdh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_range_error  = rsp_err_ff;

endmodule

`default_nettype wire
